// ===== hdl/wf3_pkg.sv =====
`timescale 1ns / 1ps

package wf3_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	// Fixed field widths
	localparam int PIX_W      = 8;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Result buffer
	localparam int FIFO_AW    = 3;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// floor(s/9) = (s * MEAN_RECIP) >> MEAN_SHIFT for every 9-pixel sum
	localparam int SUM_W      = 12;
	localparam int RECIP_W    = 13;
	localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;
	localparam int MEAN_SHIFT = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// Filter modes (any other code acts as median)
	localparam logic [MODE_W-1:0] MODE_GAUSS  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [8:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [FW_W-1:0]   width;
		logic [FH_W-1:0]   height;
	} cfg_t;

	typedef struct packed {
		logic emit;
		logic frame_end;
	} ctrl_t;

	typedef struct packed {
		pix_t filtered;
		logic frame_end;
	} result_t;

endpackage

// ===== hdl/window_filter_3x3_unit.sv =====
`timescale 1ns / 1ps

// 3x3 window filter for 8-bit grayscale pixels streamed in raster order.
// Input channel in_valid/in_ready/pixel takes one pixel per transfer; output
// channel out_valid/out_ready carries filtered and frame_end for each interior
// pixel (border pixels give no result). cfg_valid/cfg_ready/cfg_index/cfg_data
// writes mode (0 Gaussian, 1 mean, 2 or 3 median), frame_width, frame_height;
// cfg_ready is always high; the user must change registers only while the stream
// is idle, which the block does not enforce. Throughput is one pixel per cycle
// while in_ready is high: the line store is read once per pixel and written back
// in the next cycle at another column, so the single memory port pair sets the
// rate. A result passes memory read, window shift, compare/sum and filter select
// into an 8-entry result buffer. in_ready drops while 8 results are pending or
// in flight, so a stalled receiver holds the stream after at most 8 results are
// queued. Reset clears the row and column position, pending count and buffer,
// and loads mode 0, width 640, height 480. Line store contents are not cleared:
// every column is written on the first two rows before it is used.

module window_filter_3x3_unit import wf3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      filtered,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg_q;
	logic [CNT_W-1:0] pend_q;
	logic             accept;
	logic             pop;
	logic             emit_now;
	win_t             win;
	ctrl_t            ctrl_s2;
	logic             push;
	result_t          push_data;
	result_t          out_data;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_GAUSS;
			cfg_q.width  <= FW_W'(640);
			cfg_q.height <= FH_W'(480);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode   <= cfg_data[MODE_W-1:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data[FW_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_data[FH_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// Count results pending or in flight, hold input when the buffer could fill
	assign in_ready = pend_q < CNT_W'(FIFO_DEPTH);
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + CNT_W'(accept && emit_now) - CNT_W'(pop);
	end

	wf3_line_buf u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.pixel    (pixel),
		.cfg      (cfg_q),
		.emit_now (emit_now),
		.win      (win),
		.ctrl_s2  (ctrl_s2)
	);

	wf3_kernel u_kernel (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (cfg_q.mode),
		.win       (win),
		.ctrl_s2   (ctrl_s2),
		.push      (push),
		.push_data (push_data)
	);

	wf3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign filtered  = out_data.filtered;
	assign frame_end = out_data.frame_end;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CNT_W'(FIFO_DEPTH))
		else $error("pending result count exceeds buffer depth");

endmodule

// ===== hdl/wf3_line_buf.sv =====
`timescale 1ns / 1ps

module wf3_line_buf import wf3_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  pix_t  pixel,
	input  cfg_t  cfg,
	output logic  emit_now,
	output win_t  win,
	output ctrl_t ctrl_s2
);

	// Two previous rows packed per column: {upper, middle}
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rdata_q;

	logic [COL_W-1:0] col_q;
	logic [FH_W-1:0]  row_q;
	logic [COL_W:0]   eff_w;
	logic [FH_W-1:0]  eff_h;
	logic             last_col;
	logic             last_row;

	logic             valid_s1;
	pix_t             px_s1;
	logic [COL_W-1:0] addr_s1;
	ctrl_t            ctrl_s1;
	win_t             win_q;
	ctrl_t            ctrl_s2_q;

	pix_t up_rd;
	pix_t mid_rd;

	// Clamp frame geometry
	always_comb begin
		if (cfg.width < FW_W'(3))
			eff_w = (COL_W+1)'(3);
		else if (int'(cfg.width) > MAX_WIDTH)
			eff_w = (COL_W+1)'(MAX_WIDTH);
		else
			eff_w = (COL_W+1)'(cfg.width);
		eff_h = (cfg.height < FH_W'(3)) ? FH_W'(3) : cfg.height;
	end

	assign last_col = {1'b0, col_q} >= (eff_w - (COL_W+1)'(1));
	assign last_row = row_q >= (eff_h - FH_W'(1));
	assign emit_now = (row_q >= FH_W'(2)) && (col_q >= COL_W'(2));

	// Advance column and row position on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + FH_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1 and stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			ctrl_s1   <= '0;
			ctrl_s2_q <= '0;
		end else begin
			valid_s1  <= accept;
			ctrl_s1   <= '{emit: emit_now, frame_end: emit_now && last_col && last_row};
			ctrl_s2_q <= valid_s1 ? ctrl_s1 : '0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			addr_s1 <= col_q;
		end
	end

	assign up_rd  = rdata_q[2*PIX_W-1:PIX_W];
	assign mid_rd = rdata_q[PIX_W-1:0];

	// Read the column on transfer, write back shifted rows in the next cycle
	always_ff @(posedge clk) begin
		if (accept)
			rdata_q <= mem[col_q];
		if (valid_s1)
			mem[addr_s1] <= {mid_rd, px_s1};
	end

	// Shift the window by one column
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= up_rd;
			win_q[5] <= mid_rd;
			win_q[8] <= px_s1;
		end
	end

	assign win     = win_q;
	assign ctrl_s2 = ctrl_s2_q;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		accept && valid_s1 |-> col_q != addr_s1)
		else $error("line store read and write hit the same column");

	a_frame_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_s2.frame_end |-> ctrl_s2.emit)
		else $error("frame end flagged on a border pixel");

endmodule

// ===== hdl/wf3_kernel.sv =====
`timescale 1ns / 1ps

module wf3_kernel import wf3_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MODE_W-1:0] mode,
	input  win_t              win,
	input  ctrl_t             ctrl_s2,
	output logic              push,
	output result_t           push_data
);

	ctrl_t            ctrl_s3;
	logic [SUM_W-1:0] gsum_s3;
	logic [SUM_W-1:0] msum_s3;
	logic [8:0]       lt_s3 [9];
	logic [8:0]       le_s3 [9];
	win_t             win_s3;

	logic [9:0]       corners;
	logic [9:0]       edges;
	logic [SUM_W+RECIP_W-1:0] prod;
	pix_t             mean_px;
	pix_t             med_px;
	pix_t             res_px;

	// Stage 2 sums
	assign corners = 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
	assign edges   = 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctrl_s3 <= '0;
		else
			ctrl_s3 <= ctrl_s2;
	end

	// Stage 2: sums and the pairwise compare matrix
	always_ff @(posedge clk) begin
		if (ctrl_s2.emit) begin
			gsum_s3 <= SUM_W'({win[4], 2'b00}) + SUM_W'({edges, 1'b0}) + SUM_W'(corners);
			msum_s3 <= SUM_W'(corners) + SUM_W'(edges) + SUM_W'(win[4]);
			win_s3  <= win;
			for (int i = 0; i < 9; i++) begin
				for (int j = 0; j < 9; j++) begin
					lt_s3[i][j] <= win[j] <  win[i];
					le_s3[i][j] <= win[j] <= win[i];
				end
			end
		end
	end

	// Stage 3: mean by reciprocal
	assign prod    = (SUM_W+RECIP_W)'(msum_s3) * (SUM_W+RECIP_W)'(MEAN_RECIP);
	assign mean_px = prod[MEAN_SHIFT +: PIX_W];

	// Stage 3: median is the first value with at most four below and at least five at or below
	always_comb begin
		logic found;
		found  = 1'b0;
		med_px = win_s3[4];
		for (int i = 0; i < 9; i++) begin
			if (!found && ($countones(lt_s3[i]) <= 4) && ($countones(le_s3[i]) >= 5)) begin
				med_px = win_s3[i];
				found  = 1'b1;
			end
		end
	end

	// Select the filter output
	always_comb begin
		case (mode)
			MODE_GAUSS:  res_px = gsum_s3[SUM_W-1:4];
			MODE_MEAN:   res_px = mean_px;
			MODE_MEDIAN: res_px = med_px;
			default:     res_px = med_px;
		endcase
	end

	assign push      = ctrl_s3.emit;
	assign push_data = '{filtered: res_px, frame_end: ctrl_s3.frame_end};

endmodule

// ===== hdl/wf3_out_fifo.sv =====
`timescale 1ns / 1ps

module wf3_out_fifo import wf3_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t            buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               pop;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_data  = buf_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store results
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != CNT_W'(FIFO_DEPTH))
		else $error("result buffer overflow");

endmodule
